// ===== rtl/ofe_pkg.sv =====
// Shared constants and types for the OBIS field extractor.
package ofe_pkg;

  localparam int DEF_MAX_CODE_CHARS  = 16;
  localparam int DEF_MAX_VALUE_CHARS = 32;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_CODE_LOW   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_HIGH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_LEN   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAREN_IDX  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALUE  = 3'd4;

  localparam logic [4:0] RST_CODE_LENGTH      = 5'd9;
  localparam logic [2:0] RST_PAREN_INDEX      = 3'd1;
  localparam logic [5:0] RST_MAX_VALUE_LENGTH = 6'd32;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_NOCODE  = 2'd1;
  localparam logic [1:0] ST_NOPAREN = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic       shift;
    logic       clear;
    logic [7:0] data;
  } win_ctrl_t;

endpackage

// ===== rtl/ofe_if.sv =====
// Byte input and field output channel interfaces.
interface ofe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       end_of_message;

  modport source (output valid, message_byte, end_of_message, input ready);
  modport sink (input valid, message_byte, end_of_message, output ready);
endinterface

interface ofe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       byte_valid;
  logic       field_done;
  logic [1:0] status;

  modport source (output valid, value_byte, byte_valid, field_done, status, input ready);
  modport sink (input valid, value_byte, byte_valid, field_done, status, output ready);
endinterface

// ===== rtl/obis_field_extractor.sv =====
// Each byte passes through the input register and then the result register; the window
// compare and phase update sit between the two. Throughput: one byte per cycle while
// the result register is not held by back-pressure on the field output.
// Reset: synchronous; clears the phase, counters, window fill and both valid flags,
// and loads the configuration defaults (code length 9, paren index 1, limit 32).
// Top level of the OBIS field extractor.
module obis_field_extractor import ofe_pkg::*; #(
  parameter int MAX_CODE_CHARS  = DEF_MAX_CODE_CHARS,
  parameter int MAX_VALUE_CHARS = DEF_MAX_VALUE_CHARS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ofe_in_if.sink                 byte_in,
  ofe_out_if.source              field_out
);

  localparam int LENW = $clog2(MAX_CODE_CHARS + 1);
  localparam int LIMW = $clog2(MAX_VALUE_CHARS + 1);

  logic [63:0]     code_low;
  logic [63:0]     code_high;
  logic [LENW-1:0] code_len;
  logic [2:0]      target;
  logic [LIMW-1:0] limit;
  logic            match;
  win_ctrl_t       win;

  ofe_cfg #(
    .MAX_CODE_CHARS  (MAX_CODE_CHARS),
    .MAX_VALUE_CHARS (MAX_VALUE_CHARS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .code_low  (code_low),
    .code_high (code_high),
    .code_len  (code_len),
    .target    (target),
    .limit     (limit)
  );

  ofe_window #(
    .MAX_CODE_CHARS (MAX_CODE_CHARS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .win       (win),
    .code_low  (code_low),
    .code_high (code_high),
    .code_len  (code_len),
    .match     (match)
  );

  ofe_ctrl #(
    .MAX_VALUE_CHARS (MAX_VALUE_CHARS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (byte_in.valid),
    .in_ready   (byte_in.ready),
    .in_byte    (byte_in.message_byte),
    .in_eom     (byte_in.end_of_message),
    .out_valid  (field_out.valid),
    .out_ready  (field_out.ready),
    .value_byte (field_out.value_byte),
    .byte_valid (field_out.byte_valid),
    .field_done (field_out.field_done),
    .status     (field_out.status),
    .match      (match),
    .win        (win),
    .target     (target),
    .limit      (limit)
  );

endmodule

// ===== rtl/ofe_cfg.sv =====
// Configuration registers and their clamped working values.
module ofe_cfg import ofe_pkg::*; #(
  parameter int MAX_CODE_CHARS  = DEF_MAX_CODE_CHARS,
  parameter int MAX_VALUE_CHARS = DEF_MAX_VALUE_CHARS,
  localparam int LENW = $clog2(MAX_CODE_CHARS + 1),
  localparam int LIMW = $clog2(MAX_VALUE_CHARS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [63:0]            code_low,
  output logic [63:0]            code_high,
  output logic [LENW-1:0]        code_len,
  output logic [2:0]             target,
  output logic [LIMW-1:0]        limit
);

  logic [4:0] code_length;
  logic [2:0] paren_index;
  logic [5:0] max_value_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_low         <= '0;
      code_high        <= '0;
      code_length      <= RST_CODE_LENGTH;
      paren_index      <= RST_PAREN_INDEX;
      max_value_length <= RST_MAX_VALUE_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CODE_LOW:  code_low         <= cfg_data[63:0];
        REG_CODE_HIGH: code_high        <= cfg_data[63:0];
        REG_CODE_LEN:  code_length      <= cfg_data[4:0];
        REG_PAREN_IDX: paren_index      <= cfg_data[2:0];
        REG_MAX_VALUE: max_value_length <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (code_length == 5'd0) begin
      code_len = LENW'(1);
    end else if (code_length > 5'(MAX_CODE_CHARS)) begin
      code_len = LENW'(MAX_CODE_CHARS);
    end else begin
      code_len = LENW'(code_length);
    end
    target = (paren_index == 3'd0) ? 3'd1 : paren_index;
    if (max_value_length > 6'(MAX_VALUE_CHARS)) begin
      limit = LIMW'(MAX_VALUE_CHARS);
    end else begin
      limit = LIMW'(max_value_length);
    end
  end

endmodule

// ===== rtl/ofe_window.sv =====
// Sliding byte window and code match.
module ofe_window import ofe_pkg::*; #(
  parameter int MAX_CODE_CHARS = DEF_MAX_CODE_CHARS,
  localparam int LENW = $clog2(MAX_CODE_CHARS + 1),
  localparam int CW   = $clog2(MAX_CODE_CHARS)
) (
  input  logic            clk,
  input  logic            rst,
  input  win_ctrl_t       win,
  input  logic [63:0]     code_low,
  input  logic [63:0]     code_high,
  input  logic [LENW-1:0] code_len,
  output logic            match
);

  logic [7:0]      recent [MAX_CODE_CHARS];
  logic [7:0]      shifted [MAX_CODE_CHARS];
  logic [7:0]      code_arr [MAX_CODE_CHARS];
  logic [127:0]    code_full;
  logic [LENW-1:0] fill;
  logic [LENW-1:0] fill_next;
  logic            all_eq;
  logic [LENW-1:0] pos;

  assign code_full = {code_high, code_low};

  always_comb begin
    for (int k = 0; k < MAX_CODE_CHARS; k++) begin
      code_arr[k] = code_full[8*k +: 8];
    end
    shifted[0] = win.data;
    for (int j = 1; j < MAX_CODE_CHARS; j++) begin
      shifted[j] = recent[j-1];
    end
    fill_next = (fill == LENW'(MAX_CODE_CHARS)) ? fill : fill + LENW'(1);
    all_eq = 1'b1;
    for (int j = 0; j < MAX_CODE_CHARS; j++) begin
      pos = code_len - LENW'(1) - LENW'(j);
      if (LENW'(j) < code_len) begin
        if (shifted[j] != code_arr[pos[CW-1:0]]) begin
          all_eq = 1'b0;
        end
      end
    end
    match = all_eq && (fill_next >= code_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (win.clear) begin
      fill <= '0;
    end else if (win.shift) begin
      fill <= fill_next;
    end
    if (win.shift) begin
      recent <= shifted;
    end
  end

endmodule

// ===== rtl/ofe_ctrl.sv =====
// Input register, phase sequencing and result register.
module ofe_ctrl import ofe_pkg::*; #(
  parameter int MAX_VALUE_CHARS = DEF_MAX_VALUE_CHARS,
  localparam int LIMW = $clog2(MAX_VALUE_CHARS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_eom,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      value_byte,
  output logic            byte_valid,
  output logic            field_done,
  output logic [1:0]      status,
  input  logic            match,
  output win_ctrl_t       win,
  input  logic [2:0]      target,
  input  logic [LIMW-1:0] limit
);

  typedef enum logic [1:0] {PH_SEARCH, PH_COUNT, PH_EMIT, PH_DONE} phase_t;

  phase_t          phase, phase_next;
  logic [2:0]      parens_seen, parens_next;
  logic [LIMW-1:0] value_count, count_next;
  logic            ir_valid;
  logic [7:0]      ir_byte;
  logic            ir_eom;
  logic            fire;
  logic            have, valid, done;
  logic [1:0]      stat;
  logic [2:0]      parens_inc;
  logic [LIMW-1:0] count_inc;
  logic            is_term;

  assign fire     = ir_valid && (!out_valid || out_ready);
  assign in_ready = !ir_valid || fire;

  assign win.shift = fire && (phase == PH_SEARCH);
  assign win.clear = fire && ir_eom;
  assign win.data  = ir_byte;

  always_comb begin
    phase_next  = phase;
    parens_next = parens_seen;
    count_next  = value_count;
    have        = 1'b0;
    valid       = 1'b0;
    done        = 1'b0;
    stat        = ST_FOUND;
    parens_inc  = parens_seen + 3'd1;
    count_inc   = value_count + LIMW'(1);
    is_term     = (ir_byte == CH_CLOSE) || (ir_byte == CH_STAR) || (ir_byte == CH_NUL);
    case (phase)
      PH_SEARCH: begin
        if (match) begin
          phase_next  = PH_COUNT;
          parens_next = 3'd0;
        end
      end
      PH_COUNT: begin
        if (ir_byte == CH_OPEN) begin
          parens_next = parens_inc;
          if (parens_inc >= target) begin
            count_next = '0;
            if (limit == '0) begin
              have       = 1'b1;
              done       = 1'b1;
              stat       = ST_EMPTY;
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_EMIT;
            end
          end
        end
      end
      PH_EMIT: begin
        have = 1'b1;
        if (is_term) begin
          done       = 1'b1;
          stat       = (value_count != '0) ? ST_FOUND : ST_EMPTY;
          phase_next = PH_DONE;
        end else begin
          valid      = 1'b1;
          count_next = count_inc;
          if (count_inc >= limit) begin
            done       = 1'b1;
            phase_next = PH_DONE;
          end
        end
      end
      default: ;
    endcase
    if (ir_eom) begin
      if (!done) begin
        case (phase_next)
          PH_SEARCH: begin
            have = 1'b1;
            done = 1'b1;
            stat = ST_NOCODE;
          end
          PH_COUNT: begin
            have = 1'b1;
            done = 1'b1;
            stat = ST_NOPAREN;
          end
          PH_EMIT: begin
            have = 1'b1;
            done = 1'b1;
            stat = (count_next != '0) ? ST_FOUND : ST_EMPTY;
          end
          default: ;
        endcase
      end
      phase_next  = PH_SEARCH;
      parens_next = 3'd0;
      count_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid    <= 1'b0;
      out_valid   <= 1'b0;
      phase       <= PH_SEARCH;
      parens_seen <= 3'd0;
      value_count <= '0;
    end else begin
      if (in_ready) begin
        ir_valid <= in_valid;
      end
      if (fire) begin
        out_valid   <= have;
        phase       <= phase_next;
        parens_seen <= parens_next;
        value_count <= count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_ready && in_valid) begin
      ir_byte <= in_byte;
      ir_eom  <= in_eom;
    end
    if (fire && have) begin
      value_byte <= valid ? ir_byte : 8'd0;
      byte_valid <= valid;
      field_done <= done;
      status     <= done ? stat : ST_FOUND;
    end
  end

endmodule

// ===== rtl/ofe_checker.sv =====
// Port-level checks for the OBIS field extractor and their binding.
module ofe_checker import ofe_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] value_byte,
  input logic       byte_valid,
  input logic       field_done,
  input logic [1:0] status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_byte) && $stable(byte_valid)
      && $stable(field_done) && $stable(status))
    else $error("stalled result changed");

  a_value_or_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_valid || field_done)
    else $error("result carries neither a value byte nor a final status");

  a_char_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid && field_done |-> status == ST_FOUND)
    else $error("closing value character without found status");

  a_no_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> value_byte == 8'd0)
    else $error("value byte nonzero on status-only result");

  a_status_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !field_done |-> status == ST_FOUND)
    else $error("status set on non-final result");

endmodule

bind obis_field_extractor ofe_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (field_out.valid),
  .out_ready  (field_out.ready),
  .value_byte (field_out.value_byte),
  .byte_valid (field_out.byte_valid),
  .field_done (field_out.field_done),
  .status     (field_out.status)
);

// ===== tb/sv/obis_field_extractor_tb.sv =====
// Self-checking testbench for the OBIS field extractor: scoreboard against a telegram scan model.
module obis_field_extractor_tb;
  import ofe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CODE     = DEF_MAX_CODE_CHARS;
  localparam int MAX_VALUE    = DEF_MAX_VALUE_CHARS;
  localparam int DRAIN_CYCLES = 8;
  localparam int DRAIN_GUARD  = 20000;

  typedef enum logic [1:0] {HUNT, COUNT_PARENS, COPY_VALUE, CLOSED} scan_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       field_done;
    logic [1:0] status;
  } field_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ofe_in_if  byte_in ();
  ofe_out_if field_out ();

  obis_field_extractor dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_in   (byte_in),
    .field_out (field_out)
  );

  // scan model: configuration
  logic [63:0] code_lo    = '0;
  logic [63:0] code_hi    = '0;
  logic [4:0]  code_len   = RST_CODE_LENGTH;
  logic [2:0]  paren_sel  = RST_PAREN_INDEX;
  logic [5:0]  value_max  = RST_MAX_VALUE_LENGTH;

  // scan model: telegram state
  logic [7:0]  window [MAX_CODE];
  int          window_fill;
  scan_t       scan;
  logic [2:0]  parens;
  logic [5:0]  copied;

  field_t      field_q [$];
  logic [7:0]  code_chars [MAX_CODE];
  logic [7:0]  tele [$];
  string       value_set = "0123456789.-kWhAV";

  int burst_left  = 0;
  int hold_cycles = 0;
  int errors      = 0;
  int n_bytes     = 0;
  int n_results   = 0;
  int n_fields    = 0;
  int n_telegrams = 0;
  int n_settings  = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [7:0] code_char(input int i);
    if (i < 8) begin
      return code_lo[8*i +: 8];
    end
    return code_hi[8*(i-8) +: 8];
  endfunction

  function automatic int code_span();
    if (code_len == 0) begin
      return 1;
    end
    if (code_len > MAX_CODE) begin
      return MAX_CODE;
    end
    return code_len;
  endfunction

  function automatic bit code_seen();
    int n;
    n = code_span();
    if (window_fill < n) begin
      return 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      if (window[n-1-i] != code_char(i)) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [2:0] paren_target();
    return (paren_sel == 0) ? 3'd1 : paren_sel;
  endfunction

  task automatic clear_telegram();
    foreach (window[i]) window[i] = 8'h00;
    window_fill = 0;
    scan        = HUNT;
    parens      = '0;
    copied      = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic eom);
    field_t     r;
    logic       have;
    logic       done;
    logic [5:0] lim;
    r    = '0;
    have = 1'b0;
    done = 1'b0;
    lim  = (value_max > MAX_VALUE) ? 6'(MAX_VALUE) : value_max;
    case (scan)
      HUNT: begin
        for (int i = MAX_CODE - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = b;
        if (window_fill < MAX_CODE) begin
          window_fill++;
        end
        if (code_seen()) begin
          scan   = COUNT_PARENS;
          parens = '0;
        end
      end
      COUNT_PARENS: begin
        if (b == CH_OPEN) begin
          parens = parens + 3'd1;
          if (parens >= paren_target()) begin
            copied = '0;
            if (lim == 0) begin
              have     = 1'b1;
              done     = 1'b1;
              r.status = ST_EMPTY;
              scan     = CLOSED;
            end else begin
              scan = COPY_VALUE;
            end
          end
        end
      end
      COPY_VALUE: begin
        if (b == CH_CLOSE || b == CH_STAR || b == CH_NUL) begin
          have     = 1'b1;
          done     = 1'b1;
          r.status = (copied > 0) ? ST_FOUND : ST_EMPTY;
          scan     = CLOSED;
        end else begin
          have         = 1'b1;
          r.byte_valid = 1'b1;
          r.value_byte = b;
          copied       = copied + 6'd1;
          if (copied >= lim) begin
            done     = 1'b1;
            r.status = ST_FOUND;
            scan     = CLOSED;
          end
        end
      end
      default: ;
    endcase
    if (eom) begin
      if (!done) begin
        case (scan)
          HUNT: begin
            have     = 1'b1;
            done     = 1'b1;
            r.status = ST_NOCODE;
          end
          COUNT_PARENS: begin
            have     = 1'b1;
            done     = 1'b1;
            r.status = ST_NOPAREN;
          end
          COPY_VALUE: begin
            have     = 1'b1;
            done     = 1'b1;
            r.status = (copied > 0) ? ST_FOUND : ST_EMPTY;
          end
          default: ;
        endcase
      end
      clear_telegram();
    end
    if (have) begin
      r.field_done = done;
      field_q.push_back(r);
      if (done) begin
        n_fields++;
      end
    end
  endtask

  // sender: bursts of random length with random gaps
  task automatic send_byte(input logic [7:0] b, input logic eom);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        byte_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_in.valid          <= 1'b1;
    byte_in.message_byte   <= b;
    byte_in.end_of_message <= eom;
    do @(posedge clk); while (!byte_in.ready);
    predict_byte(b, eom);
    n_bytes++;
  endtask

  task automatic send_text(input string s, input bit eom_last);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eom_last && (i == s.len() - 1));
    end
    n_telegrams += eom_last;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    byte_in.valid <= 1'b0;
    while (field_q.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_CODE_LOW:  code_lo   = data;
      REG_CODE_HIGH: code_hi   = data;
      REG_CODE_LEN:  code_len  = data[4:0];
      REG_PAREN_IDX: paren_sel = data[2:0];
      REG_MAX_VALUE: value_max = data[5:0];
      default: ;
    endcase
  endtask

  task automatic set_code(input string s);
    for (int i = 0; i < MAX_CODE; i++) begin
      code_chars[i] = (i < s.len()) ? s[i] : 8'h00;
    end
  endtask

  task automatic apply_config(input logic [4:0] len, input logic [2:0] paren,
                              input logic [5:0] maxlen);
    logic [63:0] lo;
    logic [63:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = code_chars[i];
      hi[8*i +: 8] = code_chars[i+8];
    end
    drain();
    put_reg(REG_CODE_LOW, lo);
    put_reg(REG_CODE_HIGH, hi);
    put_reg(REG_CODE_LEN, 64'(len));
    put_reg(REG_PAREN_IDX, 64'(paren));
    put_reg(REG_MAX_VALUE, 64'(maxlen));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [7:0] value_char();
    if ($urandom_range(0, 15) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return value_set[$urandom_range(0, value_set.len() - 1)];
  endfunction

  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    return (c == CH_OPEN) ? 8'h2D : c;
  endfunction

  function automatic logic [7:0] noise_char();
    if ($urandom_range(0, 7) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return 8'($urandom_range(32, 126));
  endfunction

  task automatic push_code(input int n);
    for (int i = 0; i < n; i++) tele.push_back(code_chars[i]);
  endtask

  task automatic send_telegram();
    int kind;
    int vlen;
    int term;
    kind = $urandom_range(0, 9);
    tele.delete();
    repeat ($urandom_range(0, 6)) tele.push_back(noise_char());
    if (kind <= 5) begin
      push_code(code_span());
      repeat ($urandom_range(1, 5)) begin
        repeat ($urandom_range(0, 2)) tele.push_back(filler_char());
        tele.push_back(CH_OPEN);
        vlen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
        repeat (vlen) tele.push_back(value_char());
        term = $urandom_range(0, 9);
        if (term < 6) begin
          tele.push_back(CH_CLOSE);
        end else if (term < 9) begin
          tele.push_back(CH_STAR);
          tele.push_back(8'h56);
          tele.push_back(CH_CLOSE);
        end else begin
          tele.push_back(CH_NUL);
        end
      end
      repeat ($urandom_range(0, 3)) tele.push_back(noise_char());
    end else if (kind == 6) begin
      push_code(code_span() - 1);
      tele.push_back(CH_OPEN);
      tele.push_back(value_char());
      tele.push_back(CH_CLOSE);
    end else if (kind == 7) begin
      push_code(code_span());
      repeat ($urandom_range(1, 6)) tele.push_back(filler_char());
    end else if (kind == 8) begin
      push_code(code_span());
      repeat (paren_target()) tele.push_back(CH_OPEN);
      repeat ($urandom_range(1, 10)) tele.push_back(value_char());
    end else begin
      repeat ($urandom_range(1, 12)) tele.push_back(8'($urandom_range(0, 255)));
    end
    foreach (tele[i]) send_byte(tele[i], i == tele.size() - 1);
    n_telegrams++;
  endtask

  task automatic random_setting();
    int n;
    n = $urandom_range(1, 16);
    for (int i = 0; i < MAX_CODE; i++) begin
      code_chars[i] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                      value_set[$urandom_range(0, 11)];
    end
    apply_config(($urandom_range(0, 5) == 0) ? 5'($urandom_range(17, 31)) : 5'(n),
                 ($urandom_range(0, 7) == 0) ? 3'd0 : 3'($urandom_range(1, 4)),
                 ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63)) :
                 ($urandom_range(0, 2) == 0) ? 6'($urandom_range(1, 32)) :
                                               6'($urandom_range(1, 12)));
  endtask

  task automatic test_reset_defaults();
    repeat (9) send_byte(CH_NUL, 1'b0);
    send_text("(7)", 1'b1);
  endtask

  task automatic test_directed_cases();
    string big;
    set_code("1-0:1.8.1");
    apply_config(5'd9, 3'd1, 6'd32);
    send_text("1-0:1.8.1(42*kWh)", 1'b1);
    send_text("1-0:1.8.1(7)\n", 1'b1);
    send_text("0-0:1.8.1(5)", 1'b1);
    send_text("1-0:1.8.1x", 1'b1);
    send_text("1-0:1.8.1()", 1'b1);
    send_text("1-0:1.8.1(12", 1'b1);
    send_text("1-0:1.8.1(9", 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte(8'hFF, 1'b1);
    n_telegrams++;
    send_byte(8'hFF, 1'b1);
    send_byte(CH_NUL, 1'b1);
    n_telegrams += 2;
    send_text("1-0:1", 1'b1);
    send_text(".8.1(3)", 1'b1);

    set_code("(A(");
    apply_config(5'd3, 3'd2, 6'd3);
    send_text("(A((B(CDEF)", 1'b1);

    set_code("1");
    apply_config(5'd0, 3'd0, 6'd40);
    send_text("x1((AB)", 1'b1);
    big = "X(";
    for (int i = 0; i < 34; i++) big = {big, "5"};
    set_code("X");
    apply_config(5'd1, 3'd1, 6'd40);
    send_text(big, 1'b1);
    apply_config(5'd1, 3'd1, 6'd1);
    send_text("X(ab)", 1'b1);

    set_code("0123456789ABCDEF");
    apply_config(5'd20, 3'd4, 6'd0);
    send_text("0123456789ABCDEF(((()", 1'b1);
    apply_config(5'd16, 3'd4, 6'd32);
    send_text("0123456789ABCDEF(a)(b)(c)(dd)", 1'b1);
  endtask

  task automatic test_back_pressure();
    string msg;
    set_code("1-0:2.7.0");
    apply_config(5'd9, 3'd1, 6'd32);
    msg = "1-0:2.7.0(";
    for (int i = 0; i < 32; i++) msg = {msg, "8"};
    msg = {msg, ")"};
    burst_left  = 500;
    hold_cycles = 300;
    repeat (3) send_text(msg, 1'b1);
    burst_left = 0;
  endtask

  task automatic test_random_traffic();
    int start;
    for (int p = 0; p < 10; p++) begin
      if (p == 0) begin
        set_code("1-0:31.7.0.255*x");
        apply_config(5'd16, 3'd4, 6'd32);
      end else if (p == 1) begin
        set_code("7");
        apply_config(5'd1, 3'd1, 6'd1);
      end else begin
        random_setting();
      end
      start = n_bytes;
      while (n_bytes - start < 110) send_telegram();
    end
  endtask

  // receiver: ready pattern changes at random intervals; long hold on request
  initial begin
    int mode;
    int left;
    int tick;
    mode = 0;
    left = 0;
    tick = 0;
    field_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        field_out.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      tick++;
      case (mode)
        0: field_out.ready <= 1'b1;
        1: field_out.ready <= ($urandom_range(0, 2) != 0);
        2: field_out.ready <= (tick % 4 != 3);
        default: field_out.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    field_t want;
    if (!rst && field_out.valid && field_out.ready) begin
      n_results++;
      if (field_q.size() == 0) begin
        $error("unexpected result: value_byte %0h byte_valid %0b field_done %0b status %0d",
               field_out.value_byte, field_out.byte_valid, field_out.field_done,
               field_out.status);
        errors++;
      end else begin
        want = field_q.pop_front();
        if (field_out.value_byte !== want.value_byte) begin
          $error("value_byte: expected %0h, got %0h", want.value_byte, field_out.value_byte);
          errors++;
        end
        if (field_out.byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", want.byte_valid, field_out.byte_valid);
          errors++;
        end
        if (field_out.field_done !== want.field_done) begin
          $error("field_done: expected %0b, got %0b", want.field_done, field_out.field_done);
          errors++;
        end
        if (field_out.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, field_out.status);
          errors++;
        end
      end
    end
  end

  initial begin
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_index              <= '0;
    cfg_data               <= '0;
    byte_in.valid          <= 1'b0;
    byte_in.message_byte   <= 8'h00;
    byte_in.end_of_message <= 1'b0;
    clear_telegram();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed_cases();
    test_back_pressure();
    test_random_traffic();

    drain();
    if (field_q.size() != 0) begin
      $error("%0d expected results never arrived", field_q.size());
      errors++;
    end
    $display("summary: %0d telegrams, %0d byte transfers, %0d result transfers, %0d fields",
             n_telegrams, n_bytes, n_results, n_fields);
    $display("summary: %0d register settings, %0d mismatches", n_settings, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== obis_field_extractor.f =====
rtl/ofe_pkg.sv
rtl/ofe_if.sv
rtl/ofe_cfg.sv
rtl/ofe_window.sv
rtl/ofe_ctrl.sv
rtl/obis_field_extractor.sv
rtl/ofe_checker.sv
tb/sv/obis_field_extractor_tb.sv
